### design/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

    // Size of the history ring, in address bits.
    localparam int WINDOW_BITS = 12;
    localparam int RING_DEPTH  = 1 << WINDOW_BITS;

    localparam logic [7:0] MASK_RESET   = 8'hF0;
    localparam logic [4:0] LEN_BIAS     = 5'd3;
    localparam logic [8:0] FLAG_MARKER  = 9'h100;
    localparam logic [0:0] PHASE_TOKEN  = 1'b0;
    localparam logic [0:0] PHASE_HIGH   = 1'b1;

    typedef logic [WINDOW_BITS-1:0] ring_addr_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       stream_end;
    } result_t;

    typedef struct packed {
        logic       en;
        ring_addr_t addr;
        logic [7:0] data;
    } ring_wr_t;

endpackage

`default_nettype wire

### design/lzss_ring.sv
`default_nettype none

module lzss_ring (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lzss_pkg::ring_wr_t    wr,
    input  wire logic                  rd_en,
    input  wire lzss_pkg::ring_addr_t  rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [lzss_pkg::RING_DEPTH];
    logic [7:0] mem_q_reg;
    logic [7:0] wdata_reg;
    logic       fwd_reg;
    logic       written_reg;
    logic [lzss_pkg::WINDOW_BITS:0] fill_reg;
    logic [lzss_pkg::WINDOW_BITS:0] fill_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        wdata_reg <= wr.data;
    end

    // Writes always run upwards from entry zero, so everything below the
    // high-water mark has been written and everything above still reads as zero.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr.en && !fill_reg[lzss_pkg::WINDOW_BITS]
            && (wr.addr == fill_reg[lzss_pkg::WINDOW_BITS-1:0]))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            fwd_reg     <= 1'b0;
            written_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rd_en)
            begin
                // A read of the entry being written in the same cycle takes the new data.
                fwd_reg     <= wr.en && (wr.addr == rd_addr);
                written_reg <= {1'b0, rd_addr} < fill_reg;
            end
        end
    end

    always_comb
    begin
        priority if (fwd_reg)
        begin
            rd_data = wdata_reg;
        end
        else if (written_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = 8'h00;
        end
    end

endmodule

`default_nettype wire

### design/lzss_ofifo.sv
`default_nettype none

module lzss_ofifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lzss_pkg::result_t  push_data,
    input  wire logic               pop,
    output logic                    not_empty,
    output logic [1:0]              count,
    output lzss_pkg::result_t       head
);

    lzss_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;
    assign head      = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### design/lzss_stream_decompressor.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  compressed_byte, start_of_stream
// output    out        out_valid/out_stall  out_byte, byte_valid, last_of_run, stream_end
// config    in         cfg_valid/cfg_ready  cfg_data (length field mask)
//
// A flag byte, a reference low byte, a literal or the end marker is consumed as it is accepted. A
// reference high byte starts a copy of 3 to 18 bytes, one ring read each on the single read port;
// no further input is accepted until the last read has returned and been queued.
// The ring reads as zero after reset without a clearing pass: a high-water mark
// tracks which entries have been written. Reset is asynchronous and active low.
// While the two-entry output queue is full, input is stalled and the copy issues a read only when an entry leaves.

module lzss_stream_decompressor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] compressed_byte,
    input  wire logic       start_of_stream,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            last_of_run,
    output logic            stream_end,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    localparam int WB = lzss_pkg::WINDOW_BITS;

    logic [7:0]  mask_reg;
    logic [WB-1:0] wp_reg, wp_next;
    logic [8:0]  flag_reg, flag_next;
    logic [0:0]  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic        fin_reg, fin_next;
    logic [WB-1:0] src_reg, src_next;
    logic [4:0]  remain_reg, remain_next;
    logic        infl_reg;
    logic        infl_last_reg;

    logic        accept;
    logic        pop;
    logic        fifo_nempty;
    logic [1:0]  fifo_count;
    logic [2:0]  occupancy;
    logic        issue;
    logic        engine_idle;

    logic [WB-1:0] wp_e;
    logic [8:0]  flag_e;
    logic [0:0]  phase_e;
    logic [7:0]  held_e;
    logic        fin_e;
    logic [15:0] ref_word;
    logic [7:0]  len_bits;

    logic        lit_write;
    logic        push;
    lzss_pkg::result_t   push_data;
    lzss_pkg::result_t   head;
    lzss_pkg::ring_wr_t  ring_wr;
    logic [7:0]  rd_data;

    assign cfg_ready   = 1'b1;
    assign engine_idle = (remain_reg == 5'd0) && !infl_reg;
    assign in_stall    = !(engine_idle && (fifo_count != 2'd2));
    assign accept      = in_valid && !in_stall;
    assign pop         = fifo_nempty && !out_stall;

    // Count the byte in flight from the ring so the queue can never overflow.
    assign occupancy = {1'b0, fifo_count} + {2'b00, infl_reg};
    assign issue     = (remain_reg != 5'd0)
                       && ((occupancy < 3'd2) || ((occupancy == 3'd2) && pop));

    always_comb
    begin
        wp_e    = start_of_stream ? '0 : wp_reg;
        flag_e  = start_of_stream ? 9'd0 : flag_reg;
        phase_e = start_of_stream ? lzss_pkg::PHASE_TOKEN : phase_reg;
        held_e  = start_of_stream ? 8'd0 : held_reg;
        fin_e   = start_of_stream ? 1'b0 : fin_reg;
        ref_word = {compressed_byte | mask_reg, held_e};
        len_bits = compressed_byte & mask_reg;
    end

    always_comb
    begin
        wp_next     = wp_reg;
        flag_next   = flag_reg;
        phase_next  = phase_reg;
        held_next   = held_reg;
        fin_next    = fin_reg;
        src_next    = src_reg;
        remain_next = remain_reg;
        lit_write   = 1'b0;
        push        = 1'b0;
        push_data   = '0;

        if (accept)
        begin
            wp_next    = wp_e;
            flag_next  = flag_e;
            phase_next = phase_e;
            held_next  = held_e;
            fin_next   = fin_e;
            if (!fin_e)
            begin
                if (phase_e == lzss_pkg::PHASE_TOKEN)
                begin
                    priority if (flag_e[8:1] == 8'd0)
                    begin
                        flag_next = lzss_pkg::FLAG_MARKER | {1'b0, compressed_byte};
                    end
                    else if (flag_e[0])
                    begin
                        flag_next = flag_e >> 1;
                        lit_write = 1'b1;
                        wp_next   = wp_e + 1'b1;
                        push      = 1'b1;
                        push_data = '{out_byte: compressed_byte, byte_valid: 1'b1,
                                      last_of_run: 1'b1, stream_end: 1'b0};
                    end
                    else
                    begin
                        held_next  = compressed_byte;
                        phase_next = lzss_pkg::PHASE_HIGH;
                    end
                end
                else
                begin
                    phase_next = lzss_pkg::PHASE_TOKEN;
                    flag_next  = flag_e >> 1;
                    if ((held_e == 8'd0) && (compressed_byte == 8'd0))
                    begin
                        fin_next  = 1'b1;
                        push      = 1'b1;
                        push_data = '{out_byte: 8'd0, byte_valid: 1'b0,
                                      last_of_run: 1'b1, stream_end: 1'b1};
                    end
                    else
                    begin
                        src_next    = ref_word[WB-1:0] + wp_e;
                        remain_next = {1'b0, len_bits[7:4]} + lzss_pkg::LEN_BIAS;
                    end
                end
            end
        end

        if (issue)
        begin
            src_next    = src_reg + 1'b1;
            remain_next = remain_reg - 5'd1;
        end

        // Ring data returns in the cycle after the read; store it and queue it.
        if (infl_reg)
        begin
            wp_next   = wp_reg + 1'b1;
            push      = 1'b1;
            push_data = '{out_byte: rd_data, byte_valid: 1'b1,
                          last_of_run: infl_last_reg, stream_end: 1'b0};
        end
    end

    always_comb
    begin
        ring_wr.en   = lit_write || infl_reg;
        ring_wr.addr = lit_write ? wp_e : wp_reg;
        ring_wr.data = lit_write ? compressed_byte : rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= lzss_pkg::MASK_RESET;
            wp_reg        <= '0;
            flag_reg      <= 9'd0;
            phase_reg     <= lzss_pkg::PHASE_TOKEN;
            held_reg      <= 8'd0;
            fin_reg       <= 1'b0;
            src_reg       <= '0;
            remain_reg    <= 5'd0;
            infl_reg      <= 1'b0;
            infl_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
            wp_reg        <= wp_next;
            flag_reg      <= flag_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            fin_reg       <= fin_next;
            src_reg       <= src_next;
            remain_reg    <= remain_next;
            infl_reg      <= issue;
            infl_last_reg <= issue && (remain_reg == 5'd1);
        end
    end

    lzss_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ring_wr),
        .rd_en   (issue),
        .rd_addr (src_reg),
        .rd_data (rd_data)
    );

    lzss_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (fifo_nempty),
        .count     (fifo_count),
        .head      (head)
    );

    assign out_valid   = fifo_nempty;
    assign out_byte    = head.out_byte;
    assign byte_valid  = head.byte_valid;
    assign last_of_run = head.last_of_run;
    assign stream_end  = head.stream_end;

endmodule

`default_nettype wire

### bench/lzss_stream_decompressor_tb.sv
module lzss_stream_decompressor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the decoder state and holds the decompressed bytes still owed by the block.
    class lzss_byte_tracker;
        logic [7:0]           history [lzss_pkg::RING_DEPTH];
        lzss_pkg::ring_addr_t wr_pos;
        logic [8:0]           flag_bits;
        logic [0:0]           phase_now;
        logic [7:0]           low_byte;
        logic                 done;
        logic [7:0]           len_mask;
        lzss_pkg::result_t    due_bytes [$];
        int                   errors;
        int                   checked;
        int                   used_bytes;
        int                   ends_seen;

        function new();
            foreach (history[i]) history[i] = 8'h00;
            wr_pos     = '0;
            flag_bits  = '0;
            phase_now  = lzss_pkg::PHASE_TOKEN;
            low_byte   = 8'h00;
            done       = 1'b0;
            len_mask   = lzss_pkg::MASK_RESET;
            errors     = 0;
            checked    = 0;
            used_bytes = 0;
            ends_seen  = 0;
        endfunction

        function void owe(logic [7:0] b, logic valid, logic last, logic fin);
            lzss_pkg::result_t r;
            r.out_byte    = b;
            r.byte_valid  = valid;
            r.last_of_run = last;
            r.stream_end  = fin;
            due_bytes.push_back(r);
        endfunction

        function void keep(logic [7:0] b);
            history[wr_pos] = b;
            wr_pos++;
        endfunction

        function void take_input(logic [7:0] b, logic sos);
            lzss_pkg::ring_addr_t src;
            int                   copy_len;
            logic [7:0]           v;
            if (sos)
            begin
                wr_pos    = '0;
                flag_bits = '0;
                phase_now = lzss_pkg::PHASE_TOKEN;
                low_byte  = 8'h00;
                done      = 1'b0;
            end
            if (done)
                return;
            used_bytes++;
            if (phase_now != lzss_pkg::PHASE_HIGH)
            begin
                phase_now = lzss_pkg::PHASE_TOKEN;
                if (flag_bits <= 9'd1)
                begin
                    flag_bits = lzss_pkg::FLAG_MARKER | {1'b0, b};
                end
                else if (flag_bits[0])
                begin
                    flag_bits = flag_bits >> 1;
                    keep(b);
                    owe(b, 1'b1, 1'b1, 1'b0);
                end
                else
                begin
                    low_byte  = b;
                    phase_now = lzss_pkg::PHASE_HIGH;
                end
                return;
            end
            phase_now = lzss_pkg::PHASE_TOKEN;
            flag_bits = flag_bits >> 1;
            if (low_byte == 8'h00 && b == 8'h00)
            begin
                done = 1'b1;
                ends_seen++;
                owe(8'h00, 1'b0, 1'b1, 1'b1);
                return;
            end
            // Only the low window bits of the offset survive the wrap of the ring.
            src      = lzss_pkg::ring_addr_t'({b | len_mask, low_byte}) + wr_pos;
            copy_len = int'((b & len_mask) >> 4) + int'(lzss_pkg::LEN_BIAS);
            for (int i = 0; i < copy_len; i++)
            begin
                v = history[src];
                keep(v);
                owe(v, 1'b1, i == copy_len - 1, 1'b0);
                src++;
            end
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_output(lzss_pkg::result_t got);
            lzss_pkg::result_t want;
            if (due_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte)
                report("out_byte", want.out_byte, got.out_byte);
            if (got.byte_valid !== want.byte_valid)
                report("byte_valid", {7'd0, want.byte_valid}, {7'd0, got.byte_valid});
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", {7'd0, want.last_of_run}, {7'd0, got.last_of_run});
            if (got.stream_end !== want.stream_end)
                report("stream_end", {7'd0, want.stream_end}, {7'd0, got.stream_end});
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] compressed_byte;
    logic       start_of_stream;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       stream_end;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    lzss_byte_tracker tracker = new();
    bit               sender_gaps;
    bit               receiver_gaps;
    int               hold_cycles;
    logic [7:0]       mid_mask;

    lzss_stream_decompressor i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .compressed_byte (compressed_byte),
        .start_of_stream (start_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .last_of_run     (last_of_run),
        .stream_end      (stream_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Valid is left high after a transaction so that back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [7:0] b, input logic sos);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        compressed_byte <= b;
        start_of_stream <= sos;
        do @(posedge clk); while (in_stall);
        tracker.take_input(b, sos);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.due_bytes.size() != 0) @(posedge clk);
        // A byte that yields nothing may still be in flight.
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mask(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.len_mask = value;
    endtask

    task automatic send_stream(input int groups);
        logic [7:0] flags;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       first;
        bit         cut;
        first = 1'b1;
        cut   = ($urandom_range(0, 5) == 0);
        for (int g = 0; g < groups; g++)
        begin
            flags = 8'($urandom_range(0, 255));
            send_byte(flags, first);
            first = 1'b0;
            for (int k = 0; k < 8; k++)
            begin
                if (flags[k])
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                else
                begin
                    b1 = 8'($urandom_range(0, 255));
                    b2 = 8'($urandom_range(0, 255));
                    // Half of the references reach back only a few bytes, into fresh output.
                    if ($urandom_range(0, 1) == 1)
                    begin
                        b2[3:0] = 4'hF;
                        b1[7:5] = 3'b111;
                    end
                    if (b1 == 8'h00 && b2 == 8'h00)
                        b1 = 8'h01;
                    send_byte(b1, 1'b0);
                    // A broken stream stops after a low byte; the next one restarts it.
                    if (cut && $urandom_range(0, 7) == 0)
                        return;
                    send_byte(b2, 1'b0);
                end
            end
        end
        flags    = 8'($urandom_range(0, 255));
        flags[0] = 1'b0;
        send_byte(flags, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_random(input int target);
        while (tracker.used_bytes < target)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else
                send_stream($urandom_range(1, 3));
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (receiver_gaps && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_output(
                lzss_pkg::result_t'{out_byte, byte_valid, last_of_run, stream_end});
    end

    initial
    begin
        #4_000_000;
        $display("lzss_stream_decompressor: mismatch");
        $finish;
    end

    initial
    begin
        sender_gaps     = 1'b1;
        receiver_gaps   = 1'b1;
        hold_cycles     = 0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        compressed_byte <= 8'h00;
        start_of_stream <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_data        <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mask(lzss_pkg::MASK_RESET);
        // Literals at both extremes, a copy from never-written history, a maximum-length
        // copy overlapping its own output, a short copy, two more literals, then the end marker.
        send_byte(8'h63, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // Bytes after the end marker are dropped until a new stream starts.
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        // A restart lands in the middle of a reference and is read as a flag.
        send_byte(8'h00, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h77, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);

        drain();
        write_mask(8'hFF);
        send_random(100);

        drain();
        write_mask(8'h00);
        hold_cycles = 300;
        send_random(170);

        drain();
        mid_mask = 8'($urandom_range(1, 254));
        write_mask(mid_mask);
        send_random(205);
        drain();
        send_random(235);

        drain();
        write_mask(lzss_pkg::MASK_RESET);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        send_random(280);
        drain();

        $display("Decoded %0d compressed bytes into %0d checked results, %0d stream ends,",
                 tracker.used_bytes, tracker.checked, tracker.ends_seen);
        $display("with length masks 0xF0, 0xFF, 0x00 and 0x%02h.", mid_mask);
        if (tracker.errors == 0)
            $display("lzss_stream_decompressor: match");
        else
            $display("lzss_stream_decompressor: mismatch");
        $finish;
    end

endmodule
